// File: rtl/core/tcp_sender_window_retransmit_unit_defines.svh
// assertion macros for the tcp sender window retransmit unit
// used by the checker module only
`ifndef TCP_SENDER_WINDOW_RETRANSMIT_UNIT_DEFINES_SVH
`define TCP_SENDER_WINDOW_RETRANSMIT_UNIT_DEFINES_SVH

// check a property on the rising clock edge, disabled during reset
`define TSW_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that one condition implies another in the same cycle
`define TSW_IMPLIES(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

`endif

// File: rtl/core/tsw_pkg.sv
// package for the tcp sender window retransmit unit
// types and constants shared by the ram-backed core and its checker
`timescale 1ns / 1ps
`default_nettype none
package tsw_pkg;

  // opcodes of an input transaction
  localparam logic [2:0] OP_PUSH  = 3'd0;
  localparam logic [2:0] OP_CLOSE = 3'd1;
  localparam logic [2:0] OP_FILL  = 3'd2;
  localparam logic [2:0] OP_ACK   = 3'd3;
  localparam logic [2:0] OP_TICK  = 3'd4;
  localparam logic [2:0] OP_EMPTY = 3'd5;
  // unused codes, answered with the status result only
  localparam logic [2:0] OP_RSV6  = 3'd6;
  localparam logic [2:0] OP_RSV7  = 3'd7;

  // configuration register indexes
  localparam logic [1:0] CFG_ISEQ = 2'd0;
  localparam logic [1:0] CFG_RTO  = 2'd1;
  localparam logic [1:0] CFG_MSS  = 2'd2;
  localparam logic [1:0] CFG_CAP  = 2'd3;

  // segments emitted by one fill at most
  localparam int unsigned MaxEmit = 33;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] byte_count;
    logic [31:0] ack_number;
    logic [15:0] window_advertised;
    logic [31:0] ms_elapsed;
  } tsw_in_t;

  typedef struct packed {
    logic        seg_valid;
    logic [31:0] seg_seqno;
    logic [47:0] seg_offset;
    logic [15:0] seg_length;
    logic        seg_syn;
    logic        seg_fin;
    logic        seg_resend;
    logic [31:0] in_flight;
    logic [7:0]  retrans_count;
    logic        last;
  } tsw_out_t;

  // one outstanding segment as held in the queue memory
  typedef struct packed {
    logic [63:0] start;
    logic [47:0] offset;
    logic [15:0] len;
    logic        syn;
    logic        fin;
  } tsw_entry_t;

endpackage
`default_nettype wire

// File: rtl/core/tsw_ram.sv
// generic single-port-write, single-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module tsw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: rtl/core/tcp_sender_window_retransmit_unit.sv
// top level of the tcp sender window retransmit unit
// depends on tsw_pkg and tsw_ram
`timescale 1ns / 1ps
`default_nettype none
// Usage
// A command transaction is taken when start_i is high and busy_o is low.
// Each command yields one or more results on res_o, each valid for one
// cycle while res_valid_o is high; the final result has last set and is
// a status with seg_valid clear. The receiver cannot hold results off.
// Push, end input, empty segment and unused opcodes keep busy_o high through
// S_DATA and S_STAT; the status shows in the cycle after S_STAT, when busy_o is low.
// A tick with segments outstanding reads the queue head from memory and
// gives one result more on expiry. An ack first pops acknowledged segments,
// one memory read and one compare per entry, then fills. A fill emits each
// segment by length arithmetic, then the queue write and the result.
// The sequencer handles one command at a time; busy_o stays high until
// the status result is out. Configuration writes go through cfg_we_i at
// any idle cycle; writing initial_rto also reloads the current rto.
// Reset sets all control state to its defaults; the queue memory needs no clearing
// since entries are only read after being written.
module tcp_sender_window_retransmit_unit #(
  parameter int unsigned OUTSTANDING_DEPTH = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire tsw_pkg::tsw_in_t cmd_i,
  output logic                  busy_o,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_index_i,
  input  wire logic [31:0]      cfg_data_i,
  output logic                  res_valid_o,
  output tsw_pkg::tsw_out_t     res_o
);
  import tsw_pkg::*;

  localparam int unsigned Aw = (OUTSTANDING_DEPTH > 1) ? $clog2(OUTSTANDING_DEPTH) : 1;
  localparam int unsigned Cw = $clog2(OUTSTANDING_DEPTH + 1);
  localparam int unsigned EntW = $bits(tsw_entry_t);
  localparam logic [Cw-1:0] QFull = Cw'(OUTSTANDING_DEPTH);
  localparam logic [Aw-1:0] QLast = Aw'(OUTSTANDING_DEPTH - 1);
  localparam logic [5:0] EmitMax = 6'(MaxEmit);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_STAT   = 4'd1;
  localparam logic [3:0] S_FILL   = 4'd2;
  localparam logic [3:0] S_SEND   = 4'd3;
  localparam logic [3:0] S_POPRD  = 4'd4;
  localparam logic [3:0] S_POPCHK = 4'd5;
  localparam logic [3:0] S_TICKRD = 4'd6;
  localparam logic [3:0] S_TICKEM = 4'd7;
  localparam logic [3:0] S_ACK    = 4'd8;
  localparam logic [3:0] S_DATA   = 4'd9;

  logic [3:0] state_q, state_d;
  tsw_in_t cmd_q, cmd_d;

  logic [31:0] iseq_q, iseq_d;
  logic [15:0] irto_q, irto_d;
  logic [15:0] mss_q, mss_d;
  logic [31:0] cap_q, cap_d;

  logic [63:0] next_q, next_d, acked_q, acked_d;
  logic [31:0] flight_q, flight_d;
  logic [15:0] win_q, win_d;
  logic        fin_done_q, fin_done_d, closed_q, closed_d;
  logic [31:0] buf_q, buf_d;
  logic [47:0] read_q, read_d;
  logic [31:0] rto_q, rto_d;
  logic [7:0]  run_q, run_d;
  logic [63:0] clk_ms_q, clk_ms_d, tstart_q, tstart_d;
  logic [Aw-1:0] head_q, head_d;
  logic [Cw-1:0] cnt_q, cnt_d;
  logic [5:0]  emit_q, emit_d;

  // pending segment computed in the fill step
  logic [15:0] plen_q, plen_d;
  logic        psyn_q, psyn_d, pfin_q, pfin_d, pmore_q, pmore_d;

  logic        rv_d, rv_q;
  tsw_out_t    res_d, res_q;

  // queue memory
  logic          ram_we;
  logic [Aw-1:0] ram_waddr, ram_raddr;
  tsw_entry_t    ram_wdata, ram_rdata;
  logic [EntW-1:0] ram_rbits;

  tsw_ram #(.Width(EntW), .Depth(OUTSTANDING_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rbits)
  );
  assign ram_rdata = tsw_entry_t'(ram_rbits);

  // helper values
  logic        can_send, eof, win_gt, zero_zero;
  logic [31:0] room, mp;
  logic [31:0] len_a;
  logic [31:0] ack_off;
  logic [63:0] ack_c, ack_abs;
  logic [63:0] ent_end;
  logic [Aw:0] tail_sum;
  logic [Aw-1:0] tail;
  logic [Aw-1:0] head_inc;
  logic [63:0] clk_new;
  logic [31:0] seg_span;

  assign can_send  = (cnt_q < QFull) && (emit_q < EmitMax);
  assign eof       = closed_q && (buf_q == 32'd0);
  assign win_gt    = {16'd0, win_q} > flight_q;
  assign zero_zero = (win_q == 16'd0) && (flight_q == 32'd0);
  assign room      = {16'd0, win_q} - flight_q;
  assign mp        = (mss_q == 16'd0) ? 32'd1 : {16'd0, mss_q};
  assign len_a     = (buf_q < room) ? buf_q : room;
  assign tail_sum  = {1'b0, head_q} + (Aw+1)'(cnt_q);
  assign tail      = (tail_sum >= (Aw+1)'(OUTSTANDING_DEPTH)) ?
                     Aw'(tail_sum - (Aw+1)'(OUTSTANDING_DEPTH)) : tail_sum[Aw-1:0];
  assign head_inc  = (head_q == QLast) ? '0 : head_q + Aw'(1);
  assign clk_new   = clk_ms_q + {32'd0, cmd_q.ms_elapsed};
  assign seg_span  = {16'd0, plen_q} + {31'd0, psyn_q} + {31'd0, pfin_q};
  assign ent_end   = ram_rdata.start + {48'd0, ram_rdata.len} +
                     {63'd0, ram_rdata.syn} + {63'd0, ram_rdata.fin};

  // unwrap of the ack number against the next sequence number
  always_comb begin
    ack_off = cmd_q.ack_number - iseq_q;
    ack_c   = {next_q[63:32], ack_off};
    ack_abs = ack_c;
    if (ack_c > next_q) begin
      if ((ack_c - next_q > 64'h8000_0000) && (ack_c >= 64'h1_0000_0000)) begin
        ack_abs = ack_c - 64'h1_0000_0000;
      end
    end else if ((next_q - ack_c > 64'h8000_0000) && (ack_c < 64'hFFFF_FFFF_0000_0000)) begin
      ack_abs = ack_c + 64'h1_0000_0000;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q; cmd_d = cmd_q;
    iseq_d = iseq_q; irto_d = irto_q; mss_d = mss_q; cap_d = cap_q;
    next_d = next_q; acked_d = acked_q; flight_d = flight_q; win_d = win_q;
    fin_done_d = fin_done_q; closed_d = closed_q; buf_d = buf_q; read_d = read_q;
    rto_d = rto_q; run_d = run_q; clk_ms_d = clk_ms_q; tstart_d = tstart_q;
    head_d = head_q; cnt_d = cnt_q; emit_d = emit_q;
    plen_d = plen_q; psyn_d = psyn_q; pfin_d = pfin_q; pmore_d = pmore_q;
    rv_d = 1'b0; res_d = res_q;
    ram_we = 1'b0; ram_waddr = tail; ram_raddr = head_q;
    ram_wdata = '{start: next_q, offset: read_q, len: plen_q, syn: psyn_q, fin: pfin_q};

    // configuration writes
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ISEQ: iseq_d = cfg_data_i;
        CFG_RTO: begin
          irto_d = cfg_data_i[15:0];
          rto_d  = {16'd0, cfg_data_i[15:0]};
        end
        CFG_MSS: mss_d = cfg_data_i[15:0];
        CFG_CAP: cap_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d  = cmd_i;
          emit_d = '0;
          state_d = S_DATA;
        end
      end
      S_DATA: begin
        state_d = S_STAT;
        case (cmd_q.opcode)
          OP_PUSH: begin
            if (!closed_q) begin
              buf_d = buf_q + (({16'd0, cmd_q.byte_count} < (cap_q > buf_q ? cap_q - buf_q : 32'd0))
                      ? {16'd0, cmd_q.byte_count} : (cap_q > buf_q ? cap_q - buf_q : 32'd0));
            end
          end
          OP_CLOSE: closed_d = 1'b1;
          OP_FILL:  state_d = S_FILL;
          OP_ACK:   state_d = (next_q == 64'd0) ? S_STAT : S_ACK;
          OP_TICK:  state_d = (cnt_q == '0) ? S_STAT : S_TICKRD;
          OP_EMPTY: begin
            rv_d = 1'b1;
            res_d = '{seg_valid: 1'b1, seg_seqno: iseq_q + next_q[31:0],
                      seg_offset: read_q, seg_length: 16'd0, seg_syn: 1'b0, seg_fin: 1'b0,
                      seg_resend: 1'b0, in_flight: flight_q, retrans_count: run_q,
                      last: 1'b0};
          end
          default: ;
        endcase
      end
      S_ACK: begin
        state_d = S_STAT;
        if (ack_abs <= next_q) begin
          win_d = cmd_q.window_advertised;
          if (ack_abs > acked_q) begin
            rto_d    = {16'd0, irto_q};
            run_d    = 8'd0;
            flight_d = flight_q - 32'(ack_abs - acked_q);
            acked_d  = ack_abs;
            tstart_d = clk_ms_q;
            state_d  = (cnt_q == '0) ? S_POPCHK : S_POPRD;
          end
        end
      end
      S_POPRD: begin
        ram_raddr = head_q;
        state_d = S_POPCHK;
      end
      S_POPCHK: begin
        if ((cnt_q != '0) && (ent_end <= acked_q)) begin
          head_d = head_inc;
          cnt_d  = cnt_q - Cw'(1);
          ram_raddr = head_inc;
          state_d = (cnt_q == Cw'(1)) ? S_POPCHK : S_POPRD;
        end else if (!fin_done_q && (win_gt || zero_zero)) begin
          state_d = S_FILL;
        end else begin
          state_d = S_STAT;
        end
      end
      S_FILL: begin
        state_d = S_STAT;
        psyn_d = 1'b0; pfin_d = 1'b0; pmore_d = 1'b0; plen_d = 16'd0;
        if (can_send) begin
          if (next_q == 64'd0) begin
            psyn_d = 1'b1; state_d = S_SEND;
          end else if (emit_q == '0 && eof && !fin_done_q && (win_gt || zero_zero)) begin
            pfin_d = 1'b1; state_d = S_SEND;
          end else if (emit_q == '0 && buf_q != 32'd0 && zero_zero) begin
            plen_d = 16'd1; state_d = S_SEND;
          end else if (buf_q != 32'd0 && win_gt) begin
            plen_d  = (len_a > mp) ? mp[15:0] : len_a[15:0];
            pfin_d  = closed_q && (buf_q == {16'd0, plen_d}) && !fin_done_q &&
                      ({17'd0, win_q} > ({1'b0, flight_q} + {17'd0, plen_d}));
            pmore_d = 1'b1;
            state_d = S_SEND;
          end
        end
      end
      S_SEND: begin
        ram_we = 1'b1;
        if (cnt_q == '0) tstart_d = clk_ms_q;
        cnt_d   = cnt_q + Cw'(1);
        buf_d   = buf_q - {16'd0, plen_q};
        read_d  = read_q + {32'd0, plen_q};
        next_d  = next_q + {32'd0, seg_span};
        flight_d = flight_q + seg_span;
        if (pfin_q) fin_done_d = 1'b1;
        emit_d  = emit_q + 6'd1;
        rv_d = 1'b1;
        res_d = '{seg_valid: 1'b1, seg_seqno: iseq_q + next_q[31:0],
                  seg_offset: read_q, seg_length: plen_q, seg_syn: psyn_q, seg_fin: pfin_q,
                  seg_resend: 1'b0, in_flight: flight_q + seg_span, retrans_count: run_q,
                  last: 1'b0};
        state_d = pmore_q ? S_FILL : S_STAT;
      end
      S_TICKRD: begin
        clk_ms_d = clk_new;
        state_d  = (clk_new - tstart_q < {32'd0, rto_q}) ? S_STAT : S_TICKEM;
      end
      S_TICKEM: begin
        tstart_d = clk_ms_q;
        if (win_q != 16'd0) begin
          if (run_q != 8'hFF) run_d = run_q + 8'd1;
          rto_d = rto_q[31] ? 32'hFFFF_FFFF : {rto_q[30:0], 1'b0};
        end
        rv_d = 1'b1;
        res_d = '{seg_valid: 1'b1, seg_seqno: iseq_q + ram_rdata.start[31:0],
                  seg_offset: ram_rdata.offset, seg_length: ram_rdata.len,
                  seg_syn: ram_rdata.syn, seg_fin: ram_rdata.fin, seg_resend: 1'b1,
                  in_flight: flight_q,
                  retrans_count: (win_q != 16'd0 && run_q != 8'hFF) ? run_q + 8'd1 : run_q,
                  last: 1'b0};
        state_d = S_STAT;
      end
      S_STAT: begin
        rv_d = 1'b1;
        res_d = '0;
        res_d.in_flight = flight_q;
        res_d.retrans_count = run_q;
        res_d.last = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      iseq_q <= 32'd0; irto_q <= 16'd1000; mss_q <= 16'd1000; cap_q <= 32'd65536;
      next_q <= '0; acked_q <= '0; flight_q <= '0; win_q <= 16'd1;
      fin_done_q <= 1'b0; closed_q <= 1'b0; buf_q <= '0; read_q <= '0;
      rto_q <= 32'd1000; run_q <= '0; clk_ms_q <= '0; tstart_q <= '0;
      head_q <= '0; cnt_q <= '0; emit_q <= '0; rv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      iseq_q <= iseq_d; irto_q <= irto_d; mss_q <= mss_d; cap_q <= cap_d;
      next_q <= next_d; acked_q <= acked_d; flight_q <= flight_d; win_q <= win_d;
      fin_done_q <= fin_done_d; closed_q <= closed_d; buf_q <= buf_d; read_q <= read_d;
      rto_q <= rto_d; run_q <= run_d; clk_ms_q <= clk_ms_d; tstart_q <= tstart_d;
      head_q <= head_d; cnt_q <= cnt_d; emit_q <= emit_d; rv_q <= rv_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    plen_q <= plen_d; psyn_q <= psyn_d; pfin_q <= pfin_d; pmore_q <= pmore_d;
    res_q <= res_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = rv_q;
  assign res_o       = res_q;
endmodule
`default_nettype wire

// File: rtl/core/tsw_checker.sv
// port-level checker for the tcp sender window retransmit unit
// depends on tsw_pkg and the defines header
`timescale 1ns / 1ps
`default_nettype none
`include "tcp_sender_window_retransmit_unit_defines.svh"
module tsw_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start_i,
  input wire logic             busy_o,
  input wire logic             res_valid_o,
  input wire tsw_pkg::tsw_out_t res_o
);
  import tsw_pkg::*;

  // a taken command makes the unit busy
  `TSW_ASSERT(a_take_busy, clk_i, rst_ni, (start_i && !busy_o) |=> busy_o, "not busy")
  // status results are empty
  `TSW_IMPLIES(a_stat_empty, clk_i, rst_ni, res_valid_o && res_o.last, !res_o.seg_valid,
    "status carries a segment")
  // the status result comes out once the unit is free again
  `TSW_IMPLIES(a_last_idle, clk_i, rst_ni, res_valid_o && res_o.last, !busy_o,
    "busy during status")
  // no result unless the unit was busy just before
  `TSW_IMPLIES(a_idle_quiet, clk_i, rst_ni, res_valid_o, $past(busy_o), "stray result")
endmodule

bind tcp_sender_window_retransmit_unit tsw_checker u_tsw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
`default_nettype wire

// File: tb/tsw_checker.sv
// scoreboard for the tcp sender window retransmit unit
// depends on tsw_pkg; watches the command, config and result ports
`timescale 1ns / 1ps
`default_nettype none
module tsw_scoreboard #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire tsw_pkg::tsw_in_t  cmd_i,
  input  wire logic              busy_o,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [31:0]       cfg_data_i,
  input  wire logic              res_valid_o,
  input  wire tsw_pkg::tsw_out_t res_o,
  output int                     fail_cnt_o,
  output int                     pending_o,
  output logic [31:0]            snd_next_o,
  output logic [31:0]            snd_acked_o
);
  import tsw_pkg::*;

  // register copies
  logic [31:0] iseq, irto, mss, cap;
  // connection state
  logic [63:0] nxt, ackd, clk_ms, tstart;
  logic [31:0] flight, pwin, buffered, rto_cur;
  logic [47:0] rd_bytes;
  logic [7:0]  rrun;
  logic        fin_done, closed;
  tsw_entry_t  oq[$];
  int          emitted;
  tsw_out_t    exp_q[$];
  int          fails;

  assign fail_cnt_o  = fails;
  assign pending_o   = exp_q.size();
  assign snd_next_o  = iseq + nxt[31:0];
  assign snd_acked_o = iseq + ackd[31:0];

  // queue one expected result, flight and retransmit count as they stand now
  task automatic add_result(input logic v, input logic [31:0] sq, input logic [47:0] off,
                            input logic [15:0] len, input logic syn, input logic fin,
                            input logic rs, input logic lst);
    tsw_out_t r;
    r.seg_valid     = v;
    r.seg_seqno     = sq;
    r.seg_offset    = off;
    r.seg_length    = len;
    r.seg_syn       = syn;
    r.seg_fin       = fin;
    r.seg_resend    = rs;
    r.in_flight     = flight;
    r.retrans_count = rrun;
    r.last          = lst;
    exp_q.insert(exp_q.size(), r);
  endtask

  function automatic logic room_for_seg();
    return oq.size() < DEPTH && emitted < MaxEmit;
  endfunction

  // emit a new segment and queue it as outstanding
  task automatic send_seg(input logic [31:0] len, input logic syn, input logic fin);
    tsw_entry_t e;
    logic [31:0] span;
    span = len + {31'd0, syn} + {31'd0, fin};
    e.start  = nxt;
    e.offset = rd_bytes;
    e.len    = len[15:0];
    e.syn    = syn;
    e.fin    = fin;
    if (oq.size() == 0) tstart = clk_ms;
    oq.insert(oq.size(), e);
    buffered = buffered - len;
    rd_bytes = rd_bytes + len;
    nxt      = nxt + span;
    flight   = flight + span;
    if (fin) fin_done = 1'b1;
    emitted++;
    add_result(1'b1, iseq + e.start[31:0], e.offset, e.len, syn, fin, 1'b0, 1'b0);
  endtask

  // window fill: syn, then lone fin, then zero-window probe, then data
  task automatic fill_segments();
    logic        eof;
    logic [31:0] mp, room, len;
    logic        fin;
    eof = closed && buffered == 0;
    mp  = (mss == 0) ? 32'd1 : mss;
    if (!room_for_seg()) return;
    if (nxt == 0) begin
      send_seg(0, 1'b1, 1'b0);
      return;
    end
    if (eof && !fin_done && ({32'd0, pwin} > {32'd0, flight} || (pwin == 0 && flight == 0))) begin
      send_seg(0, 1'b0, 1'b1);
      return;
    end
    if (buffered > 0 && pwin == 0 && flight == 0) begin
      send_seg(1, 1'b0, 1'b0);
      return;
    end
    while (buffered > 0 && pwin > flight && room_for_seg()) begin
      room = pwin - flight;
      len  = (buffered < room) ? buffered : room;
      if (len > mp) len = mp;
      fin  = closed && buffered == len && !fin_done &&
             {32'd0, pwin} > {32'd0, flight} + {32'd0, len};
      send_seg(len, 1'b0, fin);
    end
  endtask

  // map a wrapped ack number to the absolute sequence nearest the checkpoint
  function automatic logic [63:0] unwrap_seq(input logic [31:0] w, input logic [63:0] cp);
    logic [31:0] off;
    logic [63:0] c;
    off = w - iseq;
    c   = {cp[63:32], 32'd0} + {32'd0, off};
    if (c > cp) begin
      if (c - cp > 64'h8000_0000 && c >= 64'h1_0000_0000) c = c - 64'h1_0000_0000;
    end else if (cp - c > 64'h8000_0000 && c < 64'hFFFF_FFFF_0000_0000) begin
      c = c + 64'h1_0000_0000;
    end
    return c;
  endfunction

  task automatic take_ack(input logic [31:0] ackno, input logic [15:0] win);
    logic [63:0] a, seg_end;
    if (nxt == 0) return;
    a = unwrap_seq(ackno, nxt);
    if (a > nxt) return;
    pwin = {16'd0, win};
    if (a <= ackd) return;
    rto_cur = irto;
    rrun    = 0;
    flight  = flight - 32'(a - ackd);
    ackd    = a;
    while (oq.size() > 0) begin
      seg_end = oq[0].start + oq[0].len + oq[0].syn + oq[0].fin;
      if (seg_end > ackd) break;
      oq.delete(0);
    end
    tstart = clk_ms;
    if (!fin_done && (pwin > flight || (pwin == 0 && flight == 0))) fill_segments();
  endtask

  task automatic run_tick(input logic [31:0] ms);
    if (oq.size() == 0) return;
    clk_ms = clk_ms + ms;
    if (clk_ms - tstart < {32'd0, rto_cur}) return;
    tstart = clk_ms;
    if (pwin != 0) begin
      if (rrun < 8'd255) rrun++;
      rto_cur = (rto_cur > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : rto_cur * 2;
    end
    add_result(1'b1, iseq + oq[0].start[31:0], oq[0].offset, oq[0].len,
               oq[0].syn, oq[0].fin, 1'b1, 1'b0);
  endtask

  // compare results, track config, predict on each accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin
    tsw_out_t    e;
    string       bad;
    logic [31:0] space, cnt;
    if (!rst_ni) begin
      iseq = 0; irto = 1000; mss = 1000; cap = 65536;
      nxt = 0; ackd = 0; clk_ms = 0; tstart = 0;
      flight = 0; pwin = 1; buffered = 0; rto_cur = 1000;
      rd_bytes = 0; rrun = 0; fin_done = 0; closed = 0;
      oq.delete();
      exp_q.delete();
      fails = 0;
    end else begin
      if (res_valid_o) begin
        if (exp_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result %h", res_o);
        end else begin
          e   = exp_q[0];
          exp_q.delete(0);
          bad = "";
          if (res_o.seg_valid !== e.seg_valid)         bad = {bad, " seg_valid"};
          if (res_o.seg_seqno !== e.seg_seqno)         bad = {bad, " seg_seqno"};
          if (res_o.seg_offset !== e.seg_offset)       bad = {bad, " seg_offset"};
          if (res_o.seg_length !== e.seg_length)       bad = {bad, " seg_length"};
          if (res_o.seg_syn !== e.seg_syn)             bad = {bad, " seg_syn"};
          if (res_o.seg_fin !== e.seg_fin)             bad = {bad, " seg_fin"};
          if (res_o.seg_resend !== e.seg_resend)       bad = {bad, " seg_resend"};
          if (res_o.in_flight !== e.in_flight)         bad = {bad, " in_flight"};
          if (res_o.retrans_count !== e.retrans_count) bad = {bad, " retrans_count"};
          if (res_o.last !== e.last)                   bad = {bad, " last"};
          if (bad != "") begin
            fails++;
            if (fails <= 10) $display("mismatch in%s: expected %h got %h", bad, e, res_o);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ISEQ: iseq = cfg_data_i;
          CFG_RTO: begin
            irto    = {16'd0, cfg_data_i[15:0]};
            rto_cur = irto;
          end
          CFG_MSS: mss = {16'd0, cfg_data_i[15:0]};
          CFG_CAP: cap = cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_o) begin
        emitted = 0;
        case (cmd_i.opcode)
          OP_PUSH: begin
            if (!closed) begin
              cnt      = {16'd0, cmd_i.byte_count};
              space    = (cap > buffered) ? cap - buffered : 32'd0;
              buffered = buffered + ((cnt < space) ? cnt : space);
            end
          end
          OP_CLOSE: closed = 1'b1;
          OP_FILL:  fill_segments();
          OP_ACK:   take_ack(cmd_i.ack_number, cmd_i.window_advertised);
          OP_TICK:  run_tick(cmd_i.ms_elapsed);
          OP_EMPTY: add_result(1'b1, iseq + nxt[31:0], rd_bytes, 0, 0, 0, 0, 0);
          default: ;
        endcase
        add_result(0, 0, 0, 0, 0, 0, 0, 1'b1);
      end
    end
  end

endmodule
`default_nettype wire

// File: tb/tb_tcp_sender_window_retransmit_unit.sv
// testbench top for the tcp sender window retransmit unit
// depends on tsw_pkg, the unit and tsw_scoreboard; drives commands and config
`timescale 1ns / 1ps
`default_nettype none
module tb_tcp_sender_window_retransmit_unit;
  import tsw_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  tsw_in_t     cmd_i = '0;
  logic        busy_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = CFG_ISEQ;
  logic [31:0] cfg_data_i = '0;
  logic        res_valid_o;
  tsw_out_t    res_o;
  int          fail_cnt, pending;
  logic [31:0] snd_next, snd_acked;
  int          accepted = 0;
  int          idle_pct = 0;

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  tcp_sender_window_retransmit_unit #(.OUTSTANDING_DEPTH(32)) u_top (
    .clk_i, .rst_ni, .start_i, .cmd_i, .busy_o, .cfg_we_i, .cfg_index_i,
    .cfg_data_i, .res_valid_o, .res_o
  );

  tsw_scoreboard #(.DEPTH(32)) u_checker (
    .clk_i, .rst_ni, .start_i, .cmd_i, .busy_o, .cfg_we_i, .cfg_index_i,
    .cfg_data_i, .res_valid_o, .res_o, .fail_cnt_o(fail_cnt), .pending_o(pending),
    .snd_next_o(snd_next), .snd_acked_o(snd_acked)
  );

  // count accepted command transactions
  always @(posedge clk_i) if (start_i && !busy_o) accepted <= accepted + 1;

  // present one command, idling first at the current rate
  task automatic issue(input logic [2:0] op, input logic [15:0] bytes, input logic [31:0] ackno,
                       input logic [15:0] win, input logic [31:0] ms);
    int n;
    while ($urandom_range(99, 0) < idle_pct) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    cmd_i   = '{opcode: op, byte_count: bytes, ack_number: ackno,
                window_advertised: win, ms_elapsed: ms};
    start_i = 1'b1;
    n       = accepted;
    do @(negedge clk_i); while (accepted == n);
  endtask

  // hold off until all predicted results are out
  task automatic drain();
    start_i = 1'b0;
    do @(negedge clk_i); while (pending != 0 || busy_o);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_cfg(input logic [31:0] s, input logic [31:0] r,
                         input logic [31:0] m, input logic [31:0] c);
    drain();
    write_cfg(CFG_ISEQ, s);
    write_cfg(CFG_RTO, r);
    write_cfg(CFG_MSS, m);
    write_cfg(CFG_CAP, c);
  endtask

  // ack somewhere inside the unacknowledged range
  function automatic logic [31:0] good_ack();
    return snd_acked + $urandom_range(snd_next - snd_acked, 0);
  endfunction

  // one random command: mostly well-formed traffic, some noise
  task automatic random_cmd();
    int          pick;
    logic [15:0] win;
    logic [31:0] ms;
    pick = $urandom_range(99, 0);
    win  = ($urandom_range(9, 0) == 0) ? 16'd0 : 16'($urandom);
    ms   = ($urandom_range(9, 0) == 0) ? $urandom : $urandom_range(1500, 0);
    if (pick < 20)      issue(OP_PUSH, 16'($urandom), $urandom, 16'($urandom), $urandom);
    else if (pick < 40) issue(OP_FILL, 16'($urandom), $urandom, 16'($urandom), $urandom);
    else if (pick < 68) issue(OP_ACK, 16'($urandom), good_ack(), win, $urandom);
    else if (pick < 86) issue(OP_TICK, 16'($urandom), $urandom, 16'($urandom), ms);
    else if (pick < 91) issue(OP_EMPTY, 16'($urandom), $urandom, 16'($urandom), $urandom);
    else if (pick < 96) issue(OP_ACK, 16'($urandom), $urandom, 16'($urandom), $urandom);
    else                issue(($urandom_range(1, 0) == 0) ? OP_RSV6 : OP_RSV7,
                              16'($urandom), $urandom, 16'($urandom), $urandom);
  endtask

  // stimulus
  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: handshake edge cases at reset settings
    issue(OP_ACK, 0, 32'd0, 16'd100, 0);             // ack before syn
    issue(OP_PUSH, 16'hFFFF, 0, 0, 0);
    issue(OP_PUSH, 16'd0, 0, 0, 0);
    issue(OP_FILL, 0, 0, 0, 0);                      // syn alone
    issue(OP_ACK, 0, snd_next, 16'd0, 0);            // zero window, probe
    issue(OP_TICK, 0, 0, 0, 32'd999);
    issue(OP_TICK, 0, 0, 0, 32'd1);                  // expiry at zero window
    issue(OP_ACK, 0, snd_next + 32'd5000, 16'd10, 0); // beyond next
    issue(OP_ACK, 0, snd_acked, 16'd30000, 0);       // duplicate, window only
    issue(OP_FILL, 0, 0, 0, 0);
    issue(OP_TICK, 0, 0, 0, 32'hFFFF_FFFF);          // expiry, rto doubles
    issue(OP_EMPTY, 0, 0, 0, 0);
    issue(OP_RSV6, 0, 0, 0, 0);
    issue(OP_RSV7, 0, 0, 0, 0);
    issue(OP_ACK, 0, snd_next, 16'hFFFF, 0);         // new ack, big refill
    issue(OP_PUSH, 16'hFFFF, 0, 0, 0);
    issue(OP_PUSH, 16'hFFFF, 0, 0, 0);               // saturates capacity
    issue(OP_FILL, 0, 0, 0, 0);

    // random phases over several register settings
    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = (ph < 2) ? 26 : (ph < 4) ? 87 : 0;
      case (ph)
        0: set_cfg(32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1);
        1: set_cfg($urandom, 32'd65535, 32'd65535, 32'hFFFF_FFFF);
        2: set_cfg($urandom, $urandom_range(65535, 1), $urandom_range(3000, 1), $urandom);
        3: set_cfg(32'h7FFF_FFFF, 32'd200, 32'd536, 32'd100000);
        4: set_cfg(32'd0, 32'd1000, 32'd1000, 32'd65536);
        default: set_cfg($urandom, 32'd1, 32'd65535, 32'd65536);
      endcase
      for (int i = 0; i < 50; i++) random_cmd();
    end

    // closing: end input, late push, then drive the fin out and acked
    idle_pct = 10;
    issue(OP_CLOSE, 0, 0, 0, 0);
    issue(OP_PUSH, 16'h1234, 0, 0, 0);
    for (int i = 0; i < 20; i++) begin
      issue(OP_ACK, 0, snd_next, 16'hFFFF, 0);
      issue(OP_FILL, 0, 0, 0, 0);
      issue(OP_TICK, 0, 0, 0, $urandom_range(3000, 0));
    end

    drain();
    repeat (20) @(negedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
